// ----- hw/rtl/cat_pkg.sv -----
// ----------------------------------------------------------------------------
// cat_pkg
// Shared types and codes for the calendar alarm table.
// ----------------------------------------------------------------------------
package cat_pkg;

   // command codes
   localparam logic [1:0] CMD_SET   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_CLR_ALL = 2'd2;
   localparam logic [1:0] CMD_TICK  = 2'd3;

   // result status codes
   localparam logic [2:0] ST_DONE     = 3'd0;
   localparam logic [2:0] ST_FIRED    = 3'd1;
   localparam logic [2:0] ST_NONE     = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   // most alarms that may fire on one tick
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = 5;

   // one slot of the table as held in memory
   typedef struct packed {
      logic [63:0] id;
      logic [26:0] date;
      logic [4:0]  mday;
      logic [2:0]  week;
      logic [17:0] time_hms;
      logic        rpt;
   } slot_type;

   // current calendar values carried by a tick
   typedef struct packed {
      logic [26:0] date;
      logic [4:0]  mday;
      logic [2:0]  wday;
      logic [17:0] time_hms;
   } now_type;

   // compare results for one slot
   typedef struct packed {
      logic fire;
      logic id_hit;
   } match_type;

endpackage

// ----- hw/rtl/cat_slot_mem.sv -----
// ----------------------------------------------------------------------------
// cat_slot_mem
// Slot payload store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cat_slot_mem #(
   parameter int NUM_SLOTS = 16,
   parameter int IDX_W     = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  cat_pkg::slot_type wr_data,
   input  logic [IDX_W-1:0]  rd_addr,
   output cat_pkg::slot_type rd_data
);

   cat_pkg::slot_type mem [NUM_SLOTS];
   cat_pkg::slot_type rd_q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_q_ff <= mem[rd_addr];
   end

   assign rd_data = rd_q_ff;

endmodule

// ----- hw/rtl/cat_match.sv -----
// ----------------------------------------------------------------------------
// cat_match
// Compares one stored slot against the current time and the request id.
// ----------------------------------------------------------------------------
module cat_match (
   input  cat_pkg::slot_type  slot,
   input  cat_pkg::now_type   now,
   input  logic [63:0]        req_id,
   output cat_pkg::match_type result
);

   logic [3:0] now_week;
   logic       date_ok;
   logic       mday_ok;
   logic       week_ok;

   // stored weekday runs 1..7, current weekday 0..6
   assign now_week = {1'b0, now.wday} + 4'd1;

   assign date_ok = (slot.date == '0) || (slot.date == now.date);
   assign mday_ok = (slot.mday == '0) || (slot.mday == now.mday);
   assign week_ok = (slot.week == '0) || ({1'b0, slot.week} == now_week);

   assign result.fire   = date_ok && mday_ok && week_ok && (slot.time_hms == now.time_hms);
   assign result.id_hit = (slot.id == req_id);

endmodule

// ----- hw/rtl/calendar_alarm_table.sv -----
// ----------------------------------------------------------------------------
// calendar_alarm_table
// Multi-slot calendar alarm table keyed by a 64-bit alarm id.
// ----------------------------------------------------------------------------
// Alarm payloads live in a single-port-read, single-port-write memory of
// NUM_SLOTS entries; per-slot valid bits are flops cleared by reset. Every
// set, clear and tick walks the memory one slot per cycle unless paused,
// between accept and finish; set and clear stop early at the slot holding
// the id, and clear-all goes from accept straight to finish. The walk
// pauses while a new alarm fires with one already held and the result
// register full, so a slow result side stretches a tick. Fired alarms come
// out in slot order, at most 16 per tick; rsp_last marks the final result
// word of each request word. Every request word yields at least one result.
// ----------------------------------------------------------------------------
module calendar_alarm_table #(
   parameter int NUM_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [63:0] req_alarm_id,
   input  logic [26:0] req_alarm_date,
   input  logic [4:0]  req_alarm_mday,
   input  logic [2:0]  req_alarm_week,
   input  logic [17:0] req_alarm_time,
   input  logic        req_repeat_req,
   input  logic [26:0] req_now_date,
   input  logic [4:0]  req_now_mday,
   input  logic [2:0]  req_now_wday,
   input  logic [17:0] req_now_time,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_fired_id,
   output logic        rsp_last
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

   // sequencer states
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;

   // latched request word
   logic [1:0]        cmd_ff;
   cat_pkg::slot_type item_ff;
   cat_pkg::now_type  now_ff;

   // walk position; memory read data always belongs to idx_ff during a scan
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic [NUM_SLOTS-1:0] valid_ff, valid_in;

   // set / clear lookup results
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic             free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;

   // tick: most recent fired id held back until we know whether it is last
   logic                     pend_ff, pend_in;
   logic [63:0]              pend_id_ff, pend_id_in;
   logic [cat_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [63:0] rsp_id_ff, rsp_id_in;
   logic        rsp_last_ff, rsp_last_in;

   // memory hookup
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [IDX_W-1:0]  mem_raddr;
   cat_pkg::slot_type mem_q;
   cat_pkg::match_type mt;

   logic accept;
   logic out_free;
   logic cur_valid;
   logic fire;
   logic stall;
   logic adv;
   logic at_end;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   cat_slot_mem #(
      .NUM_SLOTS (NUM_SLOTS),
      .IDX_W     (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (item_ff),
      .rd_addr (mem_raddr),
      .rd_data (mem_q)
   );

   cat_match u_match (
      .slot   (mem_q),
      .now    (now_ff),
      .req_id (item_ff.id),
      .result (mt)
   );

   assign cur_valid = valid_ff[idx_ff];
   assign fire      = cur_valid && mt.fire && (cnt_ff < cat_pkg::CNT_W'(cat_pkg::MAX_RESULTS));
   // a second fire needs the result register to push the held one out
   assign stall     = (cmd_ff == cat_pkg::CMD_TICK) && fire && pend_ff && !out_free;
   assign at_end    = (idx_ff == LAST_IDX);
   assign adv       = (state_ff == S_SCAN) && !stall;

   // read the next slot when advancing, re-read the same one while paused
   always_comb begin
      mem_raddr = '0;
      if (state_ff == S_SCAN) begin
         if (!adv) begin
            mem_raddr = idx_ff;
         end else if (!at_end) begin
            mem_raddr = idx_ff + IDX_W'(1);
         end
      end
   end

   // set writes its payload at the end, never while the walk reads
   assign mem_we    = (state_ff == S_FINISH) && out_free
                      && (cmd_ff == cat_pkg::CMD_SET) && (hit_ff || free_ff);
   assign mem_waddr = hit_ff ? hit_idx_ff : free_idx_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      valid_in      = valid_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      pend_in       = pend_ff;
      pend_id_in    = pend_id_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in  = '0;
               hit_in  = 1'b0;
               free_in = 1'b0;
               pend_in = 1'b0;
               cnt_in  = '0;
               state_in = (req_command == cat_pkg::CMD_CLR_ALL) ? S_FINISH : S_SCAN;
            end
         end

         S_SCAN: begin
            if (adv) begin
               if (cmd_ff == cat_pkg::CMD_TICK) begin
                  if (fire) begin
                     if (pend_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = cat_pkg::ST_FIRED;
                        rsp_id_in     = pend_id_ff;
                        rsp_last_in   = 1'b0;
                     end
                     pend_in    = 1'b1;
                     pend_id_in = mem_q.id;
                     cnt_in     = cnt_ff + cat_pkg::CNT_W'(1);
                     if (!mem_q.rpt) begin
                        valid_in[idx_ff] = 1'b0;
                     end
                  end
                  state_in = at_end ? S_FINISH : S_SCAN;
               end else begin
                  // set and clear: ids are unique among valid slots
                  if (cur_valid && mt.id_hit) begin
                     hit_in     = 1'b1;
                     hit_idx_in = idx_ff;
                     state_in   = S_FINISH;
                  end else begin
                     if (!cur_valid && !free_ff) begin
                        free_in     = 1'b1;
                        free_idx_in = idx_ff;
                     end
                     state_in = at_end ? S_FINISH : S_SCAN;
                  end
               end
               if (!at_end) begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end

         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
               case (cmd_ff)
                  cat_pkg::CMD_SET: begin
                     rsp_id_in = item_ff.id;
                     if (hit_ff) begin
                        valid_in[hit_idx_ff] = 1'b1;
                        rsp_status_in = cat_pkg::ST_DONE;
                     end else if (free_ff) begin
                        valid_in[free_idx_ff] = 1'b1;
                        rsp_status_in = cat_pkg::ST_DONE;
                     end else begin
                        rsp_status_in = cat_pkg::ST_FULL;
                     end
                  end
                  cat_pkg::CMD_CLEAR: begin
                     rsp_id_in = item_ff.id;
                     if (hit_ff) begin
                        valid_in[hit_idx_ff] = 1'b0;
                        rsp_status_in = cat_pkg::ST_DONE;
                     end else begin
                        rsp_status_in = cat_pkg::ST_NOTFOUND;
                     end
                  end
                  cat_pkg::CMD_CLR_ALL: begin
                     valid_in      = '0;
                     rsp_status_in = cat_pkg::ST_DONE;
                     rsp_id_in     = '0;
                  end
                  default: begin
                     // tick: flush the held alarm, or report nothing fired
                     if (pend_ff) begin
                        rsp_status_in = cat_pkg::ST_FIRED;
                        rsp_id_in     = pend_id_ff;
                     end else begin
                        rsp_status_in = cat_pkg::ST_NONE;
                        rsp_id_in     = '0;
                     end
                  end
               endcase
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hit_idx_ff    <= hit_idx_in;
      free_idx_ff   <= free_idx_in;
      pend_id_ff    <= pend_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
      if (accept) begin
         cmd_ff            <= req_command;
         item_ff.id        <= req_alarm_id;
         item_ff.date      <= req_alarm_date;
         item_ff.mday      <= req_alarm_mday;
         item_ff.week      <= req_alarm_week;
         item_ff.time_hms  <= req_alarm_time;
         item_ff.rpt       <= req_repeat_req;
         now_ff.date       <= req_now_date;
         now_ff.mday       <= req_now_mday;
         now_ff.wday       <= req_now_wday;
         now_ff.time_hms   <= req_now_time;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_fired_id = rsp_id_ff;
   assign rsp_last     = rsp_last_ff;

endmodule
